// ===== src/bcc_pkg.sv =====
// Shared types, character codes and escape class masks for the bracket class compiler.
package bcc_pkg;

  localparam int CLASS_BITS = 128;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_NORMAL = 5'b00010,
    PH_ESC    = 5'b00100,
    PH_HELD   = 5'b01000,
    PH_DASH   = 5'b10000
  } bcc_phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       begin_req;
  } bcc_item_t;

  typedef struct packed {
    logic                  emit;
    logic                  status;
    logic [CLASS_BITS-1:0] class_bits;
  } bcc_res_t;

  typedef struct packed {
    logic                  hit;
    logic [CLASS_BITS-1:0] mask;
  } bcc_esc_t;

  // Fixed class for an escape letter; hit is low for any other byte.
  function automatic bcc_esc_t esc_class(input logic [7:0] b);
    bcc_esc_t r;
    r.hit  = 1'b1;
    r.mask = '0;
    case (b)
      "c": r.mask = 128'h0000_0000_0000_0000_0000_0000_0c00_3f80;
      "s": r.mask = 128'h0000_0000_0000_0000_0000_0001_0000_0000;
      "S": r.mask = 128'h7fff_ffff_ffff_ffff_ffff_fffe_ffff_fffe;
      "d": r.mask = 128'h0000_0000_0000_0000_03ff_0000_0000_0000;
      "D": r.mask = 128'h7fff_ffff_ffff_ffff_fc00_ffff_ffff_fffe;
      "w": r.mask = 128'h07ff_fffe_87ff_fffe_0000_0000_0000_0000;
      "W": r.mask = 128'h7800_0001_7800_0001_ffff_ffff_ffff_fffe;
      "x": r.mask = 128'h07ff_fffe_07ff_fffe_03ff_0000_0000_0000;
      "O": r.mask = 128'h0000_0000_0000_0000_00ff_0000_0000_0000;
      "n": r.mask = 128'h0000_0000_0000_0000_0000_0000_0000_0400;
      "r": r.mask = 128'h0000_0000_0000_0000_0000_0000_0000_2000;
      "t": r.mask = 128'h0000_0000_0000_0000_0000_0000_0000_0200;
      "v": r.mask = 128'h0000_0000_0000_0000_0000_0000_0000_0800;
      "f": r.mask = 128'h0000_0000_0000_0000_0000_0000_0000_1000;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // One-hot bit for a code below 128.
  function automatic logic [CLASS_BITS-1:0] code_bit(input logic [6:0] c);
    return {{(CLASS_BITS-1){1'b0}}, 1'b1} << c;
  endfunction

  // Bits a..b inclusive, for a <= b.
  function automatic logic [CLASS_BITS-1:0] span_bits(input logic [6:0] a, input logic [6:0] b);
    logic [CLASS_BITS-1:0] ones;
    ones = '1;
    return (ones << a) & (ones >> (7'd127 - b));
  endfunction

endpackage

// ===== src/bcc_in_reg.sv =====
// Input register stage: holds one accepted item until the parser takes it.
module bcc_in_reg import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bcc_item_t in_item,
  input  logic      advance,
  output logic      item_valid,
  output bcc_item_t item
);

  logic      valid_r, valid_nxt;
  bcc_item_t item_r;
  logic      load;

  assign in_stall  = valid_r & ~advance;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/bcc_parse.sv =====
// Parser state and combinational class update for one bracket expression byte.
module bcc_parse import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  bcc_item_t item,
  output bcc_res_t  res
);

  logic [CLASS_BITS-1:0] cls_r, cls_nxt;
  logic                  inv_r, inv_nxt;
  bcc_phase_t            ph_r, ph_nxt;
  logic [7:0]            held_r, held_nxt;

  always_comb begin
    logic [7:0]            ch;
    logic                  elem;
    logic [CLASS_BITS-1:0] base;
    logic                  emit_ok;
    logic                  emit_err;
    bcc_esc_t              esc;

    ch       = item.char_code;
    elem     = 1'b0;
    base     = cls_r;
    emit_ok  = 1'b0;
    emit_err = 1'b0;
    esc      = esc_class(ch);
    cls_nxt  = cls_r;
    inv_nxt  = inv_r;
    ph_nxt   = ph_r;
    held_nxt = held_r;

    if (item.begin_req) begin
      inv_nxt  = 1'b0;
      held_nxt = '0;
      ph_nxt   = PH_NORMAL;
      if (ch == CH_CARET) begin
        cls_nxt = code_bit(7'd0);
        inv_nxt = 1'b1;
      end else begin
        elem = 1'b1;
        base = '0;
      end
    end else if (ph_r != PH_IDLE) begin
      case (ph_r)
        PH_ESC: begin
          if (ch == CH_NUL || (ch[7] && !esc.hit)) begin
            emit_err = 1'b1;
          end else if (esc.hit) begin
            cls_nxt = cls_r | esc.mask;
            ph_nxt  = PH_NORMAL;
          end else begin
            cls_nxt = cls_r | code_bit(ch[6:0]);
            ph_nxt  = PH_NORMAL;
          end
        end
        PH_HELD: begin
          if (ch == CH_DASH) begin
            ph_nxt = PH_DASH;
          end else if (held_r[7]) begin
            emit_err = 1'b1;
          end else begin
            elem = 1'b1;
            base = cls_r | code_bit(held_r[6:0]);
          end
        end
        PH_DASH: begin
          if (ch == CH_NUL) begin
            emit_err = 1'b1;
          end else if (ch == CH_CLOSE) begin
            if (held_r[7]) begin
              emit_err = 1'b1;
            end else begin
              base    = cls_r | code_bit(held_r[6:0]) | code_bit(CH_DASH[6:0]);
              emit_ok = 1'b1;
            end
          end else if (held_r[7] || ch[7] || held_r > ch) begin
            emit_err = 1'b1;
          end else begin
            cls_nxt = cls_r | span_bits(held_r[6:0], ch[6:0]);
            ph_nxt  = PH_NORMAL;
          end
        end
        default: begin
          elem = 1'b1;
        end
      endcase
    end

    // Element start: close, end of text, escape or a held literal.
    if (elem) begin
      cls_nxt = base;
      if (ch == CH_NUL) begin
        emit_err = 1'b1;
      end else if (ch == CH_CLOSE) begin
        emit_ok = 1'b1;
      end else if (ch == CH_BSLASH) begin
        ph_nxt = PH_ESC;
      end else begin
        held_nxt = ch;
        ph_nxt   = PH_HELD;
      end
    end

    res.emit       = emit_ok | emit_err;
    res.status     = emit_err;
    res.class_bits = emit_err ? '0 : (inv_nxt ? ~base : base);
    if (emit_ok || emit_err) begin
      ph_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r  <= '0;
      inv_r  <= 1'b0;
      ph_r   <= PH_IDLE;
      held_r <= '0;
    end else if (advance) begin
      cls_r  <= cls_nxt;
      inv_r  <= inv_nxt;
      ph_r   <= ph_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== src/bcc_out_reg.sv =====
// Result register: holds a finished class until the receiver takes it.
module bcc_out_reg import bcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  bcc_res_t              res,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CLASS_BITS-1:0] class_bits,
  output logic                  status
);

  logic                  valid_r, valid_nxt;
  logic [CLASS_BITS-1:0] cls_r;
  logic                  status_r;
  logic                  load;

  assign load      = advance & res.emit;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls_r    <= res.class_bits;
      status_r <= res.status;
    end
  end

  assign out_valid  = valid_r;
  assign class_bits = cls_r;
  assign status     = status_r;

endmodule

// ===== src/bracket_class_compiler.sv =====
// Top level of the bracket class compiler: input register, parser and result register.
//
// Takes the bytes of a regex bracket expression, one item per byte, starting
// with the byte after the opening '[' (marked by in_begin_req, which also
// restarts any expression in progress). When the closing ']' arrives one item
// leaves on the result channel with the 128-bit ASCII class split into
// out_class_low (codes 0..63) and out_class_high (codes 64..127), status 0.
// A malformed expression (end of text, a byte of 128 or more, or a reversed
// range) gives one item with both class words zero and status 1. Bytes that
// arrive outside an expression are dropped and give no result. Throughput is
// one item per cycle while out_stall is low; an accepted item is loaded into
// the input register, then taken through the parser into the result register.
// The parser advances only when the result register is empty or being
// emptied, so a stalled result holds the parser and, once the input register
// is full, raises in_stall in the same cycle.
module bracket_class_compiler import bcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_begin_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_class_low,
  output logic [63:0] out_class_high,
  output logic        out_status
);

  bcc_item_t             in_item;
  bcc_item_t             item;
  logic                  item_valid;
  logic                  advance;
  bcc_res_t              res;
  logic [CLASS_BITS-1:0] class_bits;

  assign in_item.char_code = in_char_code;
  assign in_item.begin_req = in_begin_req;

  // Advance the held item when the result slot is free or draining this cycle.
  assign advance = item_valid & (~out_valid | ~out_stall);

  bcc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bcc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  bcc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .res        (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .class_bits (class_bits),
    .status     (out_status)
  );

  assign out_class_low  = class_bits[63:0];
  assign out_class_high = class_bits[127:64];

endmodule
